@@ rtl/spq_pkg.sv @@
package spq_pkg;

  // operation codes of an input word
  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  // status codes of a result word
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_cmd_t;

endpackage

@@ rtl/spq_in_if.sv @@
interface spq_in_if #(
  parameter int DATA_WIDTH     = 32,
  parameter int PRIORITY_WIDTH = 8
);
  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic [DATA_WIDTH-1:0]     data_in;
  logic [PRIORITY_WIDTH-1:0] priority_in;

  modport source (output valid, output operation, output data_in, output priority_in,
                  input ready);
  modport sink   (input valid, input operation, input data_in, input priority_in,
                  output ready);
endinterface

@@ rtl/spq_out_if.sv @@
interface spq_out_if #(
  parameter int DATA_WIDTH  = 32,
  parameter int COUNT_WIDTH = 5
);
  logic                   valid;
  logic                   ready;
  logic [DATA_WIDTH-1:0]  data_out;
  logic [1:0]             status;
  logic                   queue_empty;
  logic [COUNT_WIDTH-1:0] entry_count;

  modport source (output valid, output data_out, output status, output queue_empty,
                  output entry_count, input ready);
  modport sink   (input valid, input data_out, input status, input queue_empty,
                  input entry_count, output ready);
endinterface

@@ rtl/sorted_priority_queue.sv @@
// a word accepted at one edge has its result in the output register after that edge
// throughput: one word per cycle; every cell compares and shifts in parallel each cycle
// the next word is taken while a result waits, provided the sink takes that result
// reset clears the entry count and the output valid; cell contents are not cleared
// and are only read below the entry count
module sorted_priority_queue #(
  parameter int DEPTH          = 16,
  parameter int DATA_WIDTH     = 32,
  parameter int PRIORITY_WIDTH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  spq_in_if.sink        in_i,
  spq_out_if.source     out_o
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  op_e                       op;
  logic                      accept;
  logic                      full, empty;
  cell_cmd_t                 cmd;
  logic [CW-1:0]             count_q, count_d;

  logic                      out_valid_q;
  logic [DATA_WIDTH-1:0]     out_data_q, out_data_d;
  status_e                   out_status_q, out_status_d;

  logic [DEPTH-1:0]          keep;
  logic [DEPTH-1:0]          occupied;
  logic [DATA_WIDTH-1:0]     cell_data [DEPTH];
  logic [PRIORITY_WIDTH-1:0] cell_prio [DEPTH];

  // input handshake, output register parts the two sides
  assign op         = op_e'(in_i.operation);
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);

  // decode operation into cell command, result and next count
  always_comb begin
    cmd          = '0;
    count_d      = count_q;
    out_data_d   = '0;
    out_status_d = ST_OK;
    unique case (op)
      OP_ENQ: begin
        if (full) begin
          out_status_d = ST_FULL;
        end else begin
          cmd.enq = accept;
          count_d = count_q + CW'(1);
        end
      end
      OP_DEQ: begin
        if (empty) begin
          out_status_d = ST_EMPTY;
        end else begin
          cmd.deq    = accept;
          count_d    = count_q - CW'(1);
          out_data_d = cell_data[0];
        end
      end
      OP_PEEK: begin
        if (empty) begin
          out_status_d = ST_EMPTY;
        end else begin
          out_data_d = cell_data[0];
        end
      end
      default: begin
        out_status_d = ST_OK;
      end
    endcase
  end

  // chain of cells, front at index zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      left_keep;
    logic [DATA_WIDTH-1:0]     left_data, right_data;
    logic [PRIORITY_WIDTH-1:0] left_prio, right_prio;

    assign occupied[i] = (CW'(i) < count_q);

    if (i == 0) begin : g_front
      assign left_keep = 1'b1;
      assign left_data = in_i.data_in;
      assign left_prio = in_i.priority_in;
    end else begin : g_inner
      assign left_keep = keep[i-1];
      assign left_data = cell_data[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign right_data = cell_data[i];
      assign right_prio = cell_prio[i];
    end else begin : g_mid
      assign right_data = cell_data[i+1];
      assign right_prio = cell_prio[i+1];
    end

    spq_cell #(
      .DATA_WIDTH    (DATA_WIDTH),
      .PRIORITY_WIDTH(PRIORITY_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occupied_i  (occupied[i]),
      .new_data_i  (in_i.data_in),
      .new_prio_i  (in_i.priority_in),
      .left_keep_i (left_keep),
      .left_data_i (left_data),
      .left_prio_i (left_prio),
      .right_data_i(right_data),
      .right_prio_i(right_prio),
      .keep_o      (keep[i]),
      .data_o      (cell_data[i]),
      .prio_o      (cell_prio[i])
    );
  end

  // entry count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.data_out    = out_data_q;
  assign out_o.status      = out_status_q;
  assign out_o.entry_count = count_q;
  assign out_o.queue_empty = empty;

  // count never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  // enqueue on a full queue reports full and keeps the count
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op == OP_ENQ && full |=>
      out_valid_q && out_status_q == ST_FULL && count_q == $past(count_q))
    else $error("enqueue on full queue not dropped");

  // dequeue on a held entry takes one off the count
  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op == OP_DEQ && !empty |=> count_q == $past(count_q) - CW'(1))
    else $error("dequeue did not decrement count");

  // empty queue never returns data
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == ST_EMPTY |-> out_data_q == '0)
    else $error("data returned from empty queue");

endmodule

@@ rtl/spq_cell.sv @@
module spq_cell #(
  parameter int DATA_WIDTH     = 32,
  parameter int PRIORITY_WIDTH = 8
) (
  input  logic                      clk_i,
  input  spq_pkg::cell_cmd_t        cmd_i,
  input  logic                      occupied_i,
  input  logic [DATA_WIDTH-1:0]     new_data_i,
  input  logic [PRIORITY_WIDTH-1:0] new_prio_i,
  input  logic                      left_keep_i,
  input  logic [DATA_WIDTH-1:0]     left_data_i,
  input  logic [PRIORITY_WIDTH-1:0] left_prio_i,
  input  logic [DATA_WIDTH-1:0]     right_data_i,
  input  logic [PRIORITY_WIDTH-1:0] right_prio_i,
  output logic                      keep_o,
  output logic [DATA_WIDTH-1:0]     data_o,
  output logic [PRIORITY_WIDTH-1:0] prio_o
);
  import spq_pkg::*;

  logic [DATA_WIDTH-1:0]     data_q, data_d;
  logic [PRIORITY_WIDTH-1:0] prio_q, prio_d;
  logic                      keep;

  // entry stays put when it ranks at or above the incoming one
  assign keep = occupied_i && (prio_q >= new_prio_i);

  // insert, shift towards the back, shift towards the front or hold
  always_comb begin
    data_d = data_q;
    prio_d = prio_q;
    if (cmd_i.enq && !keep) begin
      if (left_keep_i) begin
        data_d = new_data_i;
        prio_d = new_prio_i;
      end else begin
        data_d = left_data_i;
        prio_d = left_prio_i;
      end
    end else if (cmd_i.deq) begin
      data_d = right_data_i;
      prio_d = right_prio_i;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign keep_o = keep;
  assign data_o = data_q;
  assign prio_o = prio_q;

endmodule
